// ===== rtl/assert_macros.svh =====
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked out of reset
`define MSF_ASSERT_IMPL(lbl, cond, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) else $error(msg);

// next-cycle implication, checked out of reset
`define MSF_ASSERT_NEXT(lbl, cond, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) else $error(msg);

`endif

// ===== rtl/msf_pkg.sv =====
package msf_pkg;

  localparam int WORD_BITS   = 32;
  localparam int FRAC_BITS   = 16;
  localparam int SQRT_STAGES = 32;
  localparam int DIV_STAGES  = 64;
  localparam int EXP_STEPS   = FRAC_BITS;
  // exponent magnitude at or above 64.0 gives zero
  localparam int EXP_CUT_BIT = FRAC_BITS + 6;

  localparam logic [30:0] LOG2E_Q30  = 31'd1549082005;
  localparam logic [29:0] INV2PI_Q32 = 30'd683565276;

  typedef enum logic [2:0] {
    REG_CONDUCTIVITY  = 3'd0,
    REG_MASS_DENSITY  = 3'd1,
    REG_HEAT_CAPACITY = 3'd2,
    REG_SOURCE_POWER  = 3'd3,
    REG_FAR_TEMP      = 3'd4,
    REG_MAX_TEMP      = 3'd5
  } reg_index_t;

  typedef struct packed {
    logic signed [31:0] xt;
    logic signed [31:0] yt;
    logic signed [31:0] vx;
    logic signed [31:0] vy;
  } geom_t;

  typedef struct packed {
    logic        special;
    logic [62:0] kr;
  } side_t;

  function automatic logic [63:0] isqrt64(input logic [63:0] v);
    logic [63:0] rem;
    logic [63:0] r;
    logic [63:0] b;
    rem = v;
    r   = '0;
    b   = 64'h4000_0000_0000_0000;
    for (int k = 0; k < 32; k++) begin
      if (rem >= r + b) begin
        rem = rem - (r + b);
        r   = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // 2^32 * 2^(-1/2^(i+1)), built by repeated floored roots
  function automatic logic [31:0] half_root(input int i);
    logic [63:0] h;
    h = isqrt64(64'h8000_0000_0000_0000);
    for (int j = 0; j < i; j++) begin
      h = isqrt64({h[31:0], 32'h0});
    end
    return h[31:0];
  endfunction

  function automatic logic signed [31:0] sat_word(input logic signed [48:0] v);
    logic signed [31:0] res;
    if (v > 49'sd2147483647) begin
      res = 32'sh7FFF_FFFF;
    end else if (v < -49'sd2147483648) begin
      res = 32'sh8000_0000;
    end else begin
      res = v[31:0];
    end
    return res;
  endfunction

  // floor(|vel| * (r +/- off) / 2^16); the arm never goes negative since r >= |off|
  function automatic logic [47:0] face_term(input logic [31:0] r,
                                            input logic signed [31:0] off,
                                            input logic signed [31:0] vel);
    logic [31:0]        mag;
    logic signed [34:0] arm;
    logic [64:0]        prod;
    mag = vel[31] ? 32'(-vel) : vel;
    if (vel > 0) begin
      arm = $signed({3'b000, r}) + 35'(off);
    end else begin
      arm = $signed({3'b000, r}) - 35'(off);
    end
    prod = 65'(mag) * 65'(arm[32:0]);
    return (vel == 0) ? 48'h0 : prod[63:16];
  endfunction

endpackage

// ===== rtl/moving_source_temperature_field.sv =====
// moving point-source temperature evaluator, one point per input beat
// throughput: one beat per cycle while the skid stage is empty; depth comes mostly from the
// 32-stage square root and the two 64-stage restoring dividers (exponent and final quotient)
// rst is synchronous: clears all valid bits and loads the register defaults, no clearing pass
module moving_source_temperature_field (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // pos_x, pos_y, pos_z, vel_x, vel_y, start_x, start_y, sim_time, pad
  input  logic [255:0] s_tdata,
  output logic         m_tvalid,
  input  logic         m_tready,
  // temperature
  output logic [31:0]  m_tdata,
  // clamped
  output logic [0:0]   m_tuser,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [2:0]   cfg_index,
  input  logic [31:0]  cfg_data
);
  import msf_pkg::*;

  logic [30:0]        conductivity;
  logic [30:0]        mass_density;
  logic [30:0]        heat_capacity;
  logic [30:0]        source_power;
  logic signed [31:0] far_temp;
  logic signed [31:0] max_temp;

  logic en;
  logic skid_valid;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      conductivity  <= 31'd65536;
      mass_density  <= 31'd65536;
      heat_capacity <= 31'd65536;
      source_power  <= '0;
      far_temp      <= '0;
      max_temp      <= 32'sh7FFF_FFFF;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_CONDUCTIVITY:  conductivity  <= cfg_data[30:0];
        REG_MASS_DENSITY:  mass_density  <= cfg_data[30:0];
        REG_HEAT_CAPACITY: heat_capacity <= cfg_data[30:0];
        REG_SOURCE_POWER:  source_power  <= cfg_data[30:0];
        REG_FAR_TEMP:      far_temp      <= cfg_data;
        REG_MAX_TEMP:      max_temp      <= cfg_data;
        default: ;
      endcase
    end
  end

  // whole pipeline advances unless the skid stage is holding a beat
  assign en       = !skid_valid;
  assign s_tready = en;

  // input fields
  logic signed [31:0] in_px, in_py, in_pz, in_vx, in_vy, in_x0, in_y0;
  logic [30:0]        in_t;
  assign in_px = s_tdata[31:0];
  assign in_py = s_tdata[63:32];
  assign in_pz = s_tdata[95:64];
  assign in_vx = s_tdata[127:96];
  assign in_vy = s_tdata[159:128];
  assign in_x0 = s_tdata[191:160];
  assign in_y0 = s_tdata[223:192];
  assign in_t  = s_tdata[254:224];

  // s1: travel products and raw offsets
  logic               s1_valid;
  logic signed [63:0] s1_vxt, s1_vyt;
  logic signed [32:0] s1_dx, s1_dy;
  logic signed [31:0] s1_pz, s1_vx, s1_vy;
  logic signed [31:0] t_signed;
  assign t_signed = $signed({1'b0, in_t});

  always_ff @(posedge clk) begin
    if (en) begin
      s1_vxt <= 64'(in_vx) * 64'(t_signed);
      s1_vyt <= 64'(in_vy) * 64'(t_signed);
      s1_dx  <= 33'(in_px) - 33'(in_x0);
      s1_dy  <= 33'(in_py) - 33'(in_y0);
      s1_pz  <= in_pz;
      s1_vx  <= in_vx;
      s1_vy  <= in_vy;
    end
  end

  // s2: saturated offset from the source
  logic               s2_valid;
  logic signed [31:0] s2_xt, s2_yt, s2_pz, s2_vx, s2_vy;
  logic signed [48:0] dx_full, dy_full;
  assign dx_full = 49'(s1_dx) - 49'(s1_vxt >>> FRAC_BITS);
  assign dy_full = 49'(s1_dy) - 49'(s1_vyt >>> FRAC_BITS);

  always_ff @(posedge clk) begin
    if (en) begin
      s2_xt <= sat_word(dx_full);
      s2_yt <= sat_word(dy_full);
      s2_pz <= s1_pz;
      s2_vx <= s1_vx;
      s2_vy <= s1_vy;
    end
  end

  // s3: squares
  logic        s3_valid;
  logic [63:0] s3_sx, s3_sy, s3_sz;
  geom_t       s3_geom;

  always_ff @(posedge clk) begin
    if (en) begin
      s3_sx   <= 64'(64'(s2_xt) * 64'(s2_xt));
      s3_sy   <= 64'(64'(s2_yt) * 64'(s2_yt));
      s3_sz   <= 64'(64'(s2_pz) * 64'(s2_pz));
      s3_geom <= '{xt: s2_xt, yt: s2_yt, vx: s2_vx, vy: s2_vy};
    end
  end

  // s4: squared radius
  logic        s4_valid;
  logic [63:0] s4_sum;
  geom_t       s4_geom;

  always_ff @(posedge clk) begin
    if (en) begin
      s4_sum  <= s3_sx + s3_sy + s3_sz;
      s4_geom <= s3_geom;
    end
  end

  logic        rt_valid;
  logic [31:0] rt_root;
  geom_t       rt_geom;

  msf_sqrt u_sqrt (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (s4_valid),
    .in_v     (s4_sum),
    .in_side  (s4_geom),
    .out_valid(rt_valid),
    .out_root (rt_root),
    .out_side (rt_geom)
  );

  // s5: face terms, k*R, rho*cp
  logic        s5_valid;
  logic [47:0] s5_fx, s5_fy;
  logic [62:0] s5_kr;
  logic [61:0] s5_rc;
  logic        s5_rzero;

  always_ff @(posedge clk) begin
    if (en) begin
      s5_fx    <= face_term(rt_root, rt_geom.xt, rt_geom.vx);
      s5_fy    <= face_term(rt_root, rt_geom.yt, rt_geom.vy);
      s5_kr    <= 63'(conductivity) * 63'(rt_root);
      s5_rc    <= 62'(mass_density) * 62'(heat_capacity);
      s5_rzero <= (rt_root == '0);
    end
  end

  // s6: exponent numerator
  logic        s6_valid;
  logic [48:0] s6_e;
  logic [61:0] s6_rc;
  side_t       s6_side;

  always_ff @(posedge clk) begin
    if (en) begin
      s6_e    <= 49'(s5_fx) + 49'(s5_fy);
      s6_rc   <= s5_rc;
      s6_side <= '{special: s5_rzero || (s5_kr == '0), kr: s5_kr};
    end
  end

  // s7: partial products of e * rho*cp
  logic        s7_valid;
  logic [63:0] s7_p00;
  logic [61:0] s7_p01;
  logic [48:0] s7_p10;
  logic [46:0] s7_p11;
  side_t       s7_side;

  always_ff @(posedge clk) begin
    if (en) begin
      s7_p00  <= 64'(s6_e[31:0]) * 64'(s6_rc[31:0]);
      s7_p01  <= 62'(s6_e[31:0]) * 62'(s6_rc[61:32]);
      s7_p10  <= 49'(s6_e[48:32]) * 49'(s6_rc[31:0]);
      s7_p11  <= 47'(s6_e[48:32]) * 47'(s6_rc[61:32]);
      s7_side <= s6_side;
    end
  end

  // s8: full product
  logic         s8_valid;
  logic [127:0] s8_prod;
  side_t        s8_side;

  always_ff @(posedge clk) begin
    if (en) begin
      s8_prod <= 128'(s7_p00) + (128'(s7_p01) << 32) + (128'(s7_p10) << 32)
               + (128'(s7_p11) << 64);
      s8_side <= s7_side;
    end
  end

  logic        x_valid;
  logic [63:0] x_quo;
  side_t       x_side;

  msf_div u_div_exp (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (s8_valid),
    .in_hi    (s8_prod[127:64]),
    .in_lo    (s8_prod[63:0]),
    .in_d     (64'({conductivity, 17'h0})),
    .in_side  (s8_side),
    .out_valid(x_valid),
    .out_quo  (x_quo),
    .out_side (x_side)
  );

  logic        fe_valid;
  logic [32:0] fe_val;
  side_t       fe_side;

  msf_exp u_exp (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (x_valid),
    .in_x     (x_quo),
    .in_side  (x_side),
    .out_valid(fe_valid),
    .out_fe   (fe_val),
    .out_side (fe_side)
  );

  // m1..m3: Q * exp * 1/(2 pi)
  logic         m1_valid, m2_valid, m3_valid;
  logic [63:0]  m1_qf;
  logic [61:0]  m2_p0, m2_p1;
  logic [127:0] m3_sum;
  side_t        m1_side, m2_side, m3_side;

  always_ff @(posedge clk) begin
    if (en) begin
      m1_qf   <= 64'(source_power) * 64'(fe_val);
      m1_side <= fe_side;
      m2_p0   <= 62'(m1_qf[31:0]) * 62'(INV2PI_Q32);
      m2_p1   <= 62'(m1_qf[63:32]) * 62'(INV2PI_Q32);
      m2_side <= m1_side;
      m3_sum  <= 128'(m2_p0) + (128'(m2_p1) << 32);
      m3_side <= m2_side;
    end
  end

  logic        q_valid;
  logic [63:0] q_quo;
  side_t       q_side;

  msf_div u_div_out (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (m3_valid),
    .in_hi    (m3_sum[127:64]),
    .in_lo    (m3_sum[63:0]),
    .in_d     ({1'b0, m3_side.kr}),
    .in_side  (m3_side),
    .out_valid(q_valid),
    .out_quo  (q_quo),
    .out_side (q_side)
  );

  // f1: add ambient and clamp
  logic               f1_valid;
  logic [31:0]        f1_temp;
  logic               f1_clamp;
  logic signed [33:0] temp_sum;
  logic               over;
  assign temp_sum = 34'(far_temp) + $signed({2'b00, q_quo[63:32]});
  assign over     = q_side.special || (temp_sum >= 34'(max_temp));

  always_ff @(posedge clk) begin
    if (en) begin
      f1_temp  <= over ? max_temp : temp_sum[31:0];
      f1_clamp <= over;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
      s4_valid <= 1'b0;
      s5_valid <= 1'b0;
      s6_valid <= 1'b0;
      s7_valid <= 1'b0;
      s8_valid <= 1'b0;
      m1_valid <= 1'b0;
      m2_valid <= 1'b0;
      m3_valid <= 1'b0;
      f1_valid <= 1'b0;
    end else if (en) begin
      s1_valid <= s_tvalid;
      s2_valid <= s1_valid;
      s3_valid <= s2_valid;
      s4_valid <= s3_valid;
      s5_valid <= rt_valid;
      s6_valid <= s5_valid;
      s7_valid <= s6_valid;
      s8_valid <= s7_valid;
      m1_valid <= fe_valid;
      m2_valid <= m1_valid;
      m3_valid <= m2_valid;
      f1_valid <= q_valid;
    end
  end

  // output register with one skid beat behind it
  logic [31:0] skid_temp;
  logic        skid_clamp;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid   <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!m_tvalid || m_tready) begin
      if (skid_valid) begin
        m_tvalid   <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        m_tvalid <= f1_valid;
      end
    end else if (f1_valid && !skid_valid) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!m_tvalid || m_tready) begin
      if (skid_valid) begin
        m_tdata    <= skid_temp;
        m_tuser[0] <= skid_clamp;
      end else begin
        m_tdata    <= f1_temp;
        m_tuser[0] <= f1_clamp;
      end
    end else if (!skid_valid) begin
      skid_temp  <= f1_temp;
      skid_clamp <= f1_clamp;
    end
  end

  logic skid_hold;
  logic out_clamped;
  logic out_free;
  assign skid_hold   = skid_valid && m_tvalid && !m_tready;
  assign out_clamped = m_tvalid && m_tuser[0];
  assign out_free    = m_tvalid && !m_tuser[0];

`include "assert_macros.svh"

  `MSF_ASSERT_IMPL(a_skid_behind_out, skid_valid, m_tvalid, "skid beat held with empty output")
  `MSF_ASSERT_NEXT(a_skid_holds, skid_hold, skid_valid && $stable(skid_temp), "skid beat lost")
  `MSF_ASSERT_IMPL(a_clamp_value, out_clamped, m_tdata == max_temp, "bad clamp value")
  `MSF_ASSERT_IMPL(a_below_clamp, out_free, $signed(m_tdata) < max_temp, "beat above clamp")

endmodule

// ===== rtl/msf_sqrt.sv =====
module msf_sqrt (
  input  logic          clk,
  input  logic          rst,
  input  logic          en,
  input  logic          in_valid,
  input  logic [63:0]   in_v,
  input  msf_pkg::geom_t in_side,
  output logic          out_valid,
  output logic [31:0]   out_root,
  output msf_pkg::geom_t out_side
);
  import msf_pkg::*;

  logic [63:0]            stage_v [SQRT_STAGES];
  logic [63:0]            stage_r [SQRT_STAGES];
  logic [SQRT_STAGES-1:0] vld;
  geom_t                  side [SQRT_STAGES];

  // one result bit per stage, trial bit walks down two places each stage
  for (genvar i = 0; i < SQRT_STAGES; i++) begin : g_st
    localparam logic [63:0] BIT = 64'd1 << (62 - 2 * i);
    logic [63:0] v_in;
    logic [63:0] r_in;
    logic [63:0] trial;
    if (i == 0) begin : g_first
      assign v_in = in_v;
      assign r_in = '0;
    end else begin : g_rest
      assign v_in = stage_v[i-1];
      assign r_in = stage_r[i-1];
    end
    assign trial = r_in + BIT;
    always_ff @(posedge clk) begin
      if (en) begin
        if (v_in >= trial) begin
          stage_v[i] <= v_in - trial;
          stage_r[i] <= (r_in >> 1) + BIT;
        end else begin
          stage_v[i] <= v_in;
          stage_r[i] <= r_in >> 1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[SQRT_STAGES-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side[0] <= in_side;
      for (int k = 1; k < SQRT_STAGES; k++) side[k] <= side[k-1];
    end
  end

  assign out_valid = vld[SQRT_STAGES-1];
  assign out_root  = stage_r[SQRT_STAGES-1][31:0];
  assign out_side  = side[SQRT_STAGES-1];
endmodule

// ===== rtl/msf_div.sv =====
module msf_div (
  input  logic          clk,
  input  logic          rst,
  input  logic          en,
  input  logic          in_valid,
  input  logic [63:0]   in_hi,
  input  logic [63:0]   in_lo,
  input  logic [63:0]   in_d,
  input  msf_pkg::side_t in_side,
  output logic          out_valid,
  output logic [63:0]   out_quo,
  output msf_pkg::side_t out_side
);
  import msf_pkg::*;

  logic [63:0]           st_rem [DIV_STAGES];
  logic [63:0]           st_lo  [DIV_STAGES];
  logic [63:0]           st_q   [DIV_STAGES];
  logic [63:0]           st_d   [DIV_STAGES];
  logic [DIV_STAGES-1:0] sat;
  logic [DIV_STAGES-1:0] vld;
  side_t                 side [DIV_STAGES];

  // restoring division, one quotient bit per stage; remainder stays below d when in_hi < d
  for (genvar i = 0; i < DIV_STAGES; i++) begin : g_st
    logic [63:0] rem_in;
    logic [63:0] lo_in;
    logic [63:0] q_in;
    logic [63:0] d_in;
    logic [64:0] rem2;
    logic [64:0] diff;
    logic        ge;
    if (i == 0) begin : g_first
      assign rem_in = in_hi;
      assign lo_in  = in_lo;
      assign q_in   = '0;
      assign d_in   = in_d;
    end else begin : g_rest
      assign rem_in = st_rem[i-1];
      assign lo_in  = st_lo[i-1];
      assign q_in   = st_q[i-1];
      assign d_in   = st_d[i-1];
    end
    assign rem2 = {rem_in, lo_in[63]};
    assign diff = rem2 - {1'b0, d_in};
    assign ge   = rem2 >= {1'b0, d_in};
    always_ff @(posedge clk) begin
      if (en) begin
        st_rem[i] <= ge ? diff[63:0] : rem2[63:0];
        st_lo[i]  <= {lo_in[62:0], 1'b0};
        st_q[i]   <= {q_in[62:0], ge};
        st_d[i]   <= d_in;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[DIV_STAGES-2:0], in_valid};
    end
  end

  // quotient of 2^64 or more saturates
  always_ff @(posedge clk) begin
    if (en) begin
      sat     <= {sat[DIV_STAGES-2:0], in_hi >= in_d};
      side[0] <= in_side;
      for (int k = 1; k < DIV_STAGES; k++) side[k] <= side[k-1];
    end
  end

  assign out_valid = vld[DIV_STAGES-1];
  assign out_quo   = sat[DIV_STAGES-1] ? '1 : st_q[DIV_STAGES-1];
  assign out_side  = side[DIV_STAGES-1];
endmodule

// ===== rtl/msf_exp.sv =====
module msf_exp (
  input  logic          clk,
  input  logic          rst,
  input  logic          en,
  input  logic          in_valid,
  input  logic [63:0]   in_x,
  input  msf_pkg::side_t in_side,
  output logic          out_valid,
  output logic [32:0]   out_fe,
  output msf_pkg::side_t out_side
);
  import msf_pkg::*;

  typedef struct packed {
    logic [32:0]          acc;
    logic [6:0]           n;
    logic [FRAC_BITS-1:0] f;
    logic                 zero;
  } exp_stage_t;

  exp_stage_t           st [EXP_STEPS+1];
  logic [32:0]          fe;
  logic [EXP_STEPS+1:0] vld;
  side_t                side [EXP_STEPS+2];
  logic [52:0]          y_prod;

  // x * log2(e): integer part n, fraction f
  assign y_prod = 53'(in_x[EXP_CUT_BIT-1:0]) * 53'(LOG2E_Q30);

  always_ff @(posedge clk) begin
    if (en) begin
      st[0].acc  <= 33'h1_0000_0000;
      st[0].n    <= y_prod[52:30+FRAC_BITS];
      st[0].f    <= y_prod[30+FRAC_BITS-1:30];
      st[0].zero <= |in_x[63:EXP_CUT_BIT];
    end
  end

  // one fraction bit per stage, most significant first
  for (genvar j = 0; j < EXP_STEPS; j++) begin : g_step
    localparam logic [31:0] ROOT = half_root(j);
    logic [64:0] prod;
    exp_stage_t  step_next;
    assign prod = 65'(st[j].acc) * 65'(ROOT);
    always_comb begin
      step_next = st[j];
      if (st[j].f[FRAC_BITS-1-j]) step_next.acc = prod[64:32];
    end
    always_ff @(posedge clk) begin
      if (en) begin
        st[j+1] <= step_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (st[EXP_STEPS].zero || st[EXP_STEPS].n[6]) begin
        fe <= '0;
      end else begin
        fe <= st[EXP_STEPS].acc >> st[EXP_STEPS].n[5:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[EXP_STEPS:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side[0] <= in_side;
      for (int k = 1; k < EXP_STEPS + 2; k++) side[k] <= side[k-1];
    end
  end

  assign out_valid = vld[EXP_STEPS+1];
  assign out_fe    = fe;
  assign out_side  = side[EXP_STEPS+1];
endmodule

// ===== test/tb.sv =====
`timescale 1ns / 1ps

module tb;
  import msf_pkg::*;

  localparam int ONE       = 65536;
  localparam int LATENCY   = 191;
  localparam int IDLE_MAX  = 20000;
  localparam logic [63:0] LOG2E_K  = 64'd1549082005;
  localparam logic [63:0] INV2PI_K = 64'd683565276;

  typedef struct {
    logic signed [31:0] px, py, pz, vx, vy, x0, y0;
    logic [30:0]        t;
  } point_t;

  typedef struct {
    logic [31:0] temp;
    logic        clamp;
  } heat_t;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  logic [255:0] s_tdata = '0;
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  logic [31:0]  m_tdata;
  logic [0:0]   m_tuser;
  logic         cfg_valid = 1'b0;
  logic         cfg_ready;
  logic [2:0]   cfg_index = '0;
  logic [31:0]  cfg_data = '0;

  moving_source_temperature_field dut (.*);

  always #4 clk = ~clk;

  // material and source settings as the block should hold them
  logic [63:0] k_reg, rho_reg, cp_reg, pwr_reg;
  longint      amb_reg, tmax_reg;
  logic [63:0] half_tab[16];

  point_t pending_pts[$];
  heat_t  heat_expected[$];
  int     errors = 0;
  int     idle_cycles = 0;
  bit     burst_mode = 0;

  function automatic logic [63:0] root64(input logic [63:0] v);
    logic [63:0] r, b;
    r = '0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic logic [63:0] wide_div(input logic [127:0] p, input logic [63:0] d);
    if (p[127:64] >= d) return '1;
    return 64'(p / {64'd0, d});
  endfunction

  function automatic logic signed [31:0] clip32(input longint v);
    if (v > 64'sd2147483647) return 32'sh7FFF_FFFF;
    if (v < -64'sd2147483648) return 32'sh8000_0000;
    return v[31:0];
  endfunction

  function automatic logic [63:0] arm_term(input logic [63:0] r, input longint off,
                                           input longint vel);
    logic [63:0] mag, arm, prod;
    if (vel == 0) return '0;
    mag  = (vel < 0) ? 64'(-vel) : 64'(vel);
    arm  = (vel > 0) ? 64'(longint'(r) + off) : 64'(longint'(r) - off);
    prod = mag * arm;
    return prod >> 16;
  endfunction

  function automatic logic [63:0] decay(input logic [63:0] x);
    logic [63:0] y, n, f, acc;
    if (x >= (64'd64 << 16)) return '0;
    y   = (x * LOG2E_K) >> 30;
    n   = y >> 16;
    f   = y & 64'hFFFF;
    acc = 64'd1 << 32;
    for (int i = 0; i < 16; i++)
      if (f[15-i]) acc = (acc * half_tab[i]) >> 32;
    return (n >= 64) ? '0 : (acc >> n);
  endfunction

  function automatic heat_t heat_at(input point_t p);
    longint      xt, yt, temp;
    logic [63:0] sum, r, kr, e, fe, q1;
    heat_t       h;
    xt  = clip32(longint'(p.px) - longint'(p.x0) - ((longint'(p.vx) * longint'(p.t)) >>> 16));
    yt  = clip32(longint'(p.py) - longint'(p.y0) - ((longint'(p.vy) * longint'(p.t)) >>> 16));
    sum = 64'(xt * xt) + 64'(yt * yt) + 64'(longint'(p.pz) * longint'(p.pz));
    r   = root64(sum);
    kr  = k_reg * r;
    if (r == 0 || kr == 0) begin
      h.temp  = tmax_reg[31:0];
      h.clamp = 1'b1;
    end else begin
      e    = arm_term(r, xt, longint'(p.vx)) + arm_term(r, yt, longint'(p.vy));
      fe   = decay(wide_div(128'(e) * 128'(rho_reg * cp_reg), k_reg << 17));
      q1   = wide_div(128'(pwr_reg * fe) * 128'(INV2PI_K), kr);
      temp = amb_reg + longint'(q1 >> 32);
      h.clamp = (temp >= tmax_reg);
      h.temp  = h.clamp ? tmax_reg[31:0] : temp[31:0];
    end
    return h;
  endfunction

  function automatic point_t mk(input int px, py, pz, vx, vy, x0, y0, input int unsigned t);
    point_t p;
    p = '{px, py, pz, vx, vy, x0, y0, t[30:0]};
    return p;
  endfunction

  function automatic int near_val(input int span);
    return int'($urandom_range(0, 2 * span)) - span;
  endfunction

  function automatic point_t random_point();
    point_t p;
    int     style;
    style = $urandom_range(0, 9);
    if (style < 6) begin
      // source near the point, short times: exponent lands in a useful range
      p = mk(near_val(8 * ONE), near_val(8 * ONE), near_val(4 * ONE), near_val(4 * ONE),
             near_val(4 * ONE), near_val(8 * ONE), near_val(8 * ONE),
             $urandom_range(0, 4 * ONE));
    end else if (style < 8) begin
      p = mk(near_val(1 << 24), near_val(1 << 24), near_val(1 << 22), near_val(1 << 20),
             near_val(1 << 20), near_val(1 << 24), near_val(1 << 24),
             $urandom_range(0, 1 << 22));
    end else begin
      p = mk($urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
    end
    return p;
  endfunction

  // driver
  always @(posedge clk) begin
    point_t p;
    int     gap;
    if (rst) begin
      s_tvalid <= 1'b0;
      gap = 0;
    end else begin
      if (s_tvalid && s_tready) begin
        heat_expected.push_back(heat_at(p));
        gap = burst_mode ? 0 : $urandom_range(0, 8);
      end
      if (s_tvalid && !s_tready) begin
        // hold the beat
      end else if (gap > 0) begin
        gap--;
        s_tvalid <= 1'b0;
      end else if (pending_pts.size() > 0) begin
        p = pending_pts.pop_front();
        s_tdata  <= {1'b0, p.t, p.y0, p.x0, p.vy, p.vx, p.pz, p.py, p.px};
        s_tvalid <= 1'b1;
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    int    stall;
    heat_t h;
    if (rst) begin
      m_tready <= 1'b0;
      stall = 0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (heat_expected.size() == 0) begin
          $display("%0t: unexpected beat temperature %h clamped %b", $time, m_tdata, m_tuser);
          errors++;
        end else begin
          h = heat_expected.pop_front();
          if (m_tdata !== h.temp) begin
            $display("%0t: temperature expected %h actual %h", $time, h.temp, m_tdata);
            errors++;
          end
          if (m_tuser[0] !== h.clamp) begin
            $display("%0t: clamped expected %b actual %b", $time, h.clamp, m_tuser[0]);
            errors++;
          end
        end
        stall = burst_mode ? 0 : $urandom_range(0, 8);
      end
      if (stall > 0) begin
        stall--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready) || rst)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_MAX) begin
      $display("tb: errors");
      $finish;
    end
  end

  task automatic write_reg(input reg_index_t idx, input logic [31:0] v);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      REG_CONDUCTIVITY:  k_reg    = {33'd0, v[30:0]};
      REG_MASS_DENSITY:  rho_reg  = {33'd0, v[30:0]};
      REG_HEAT_CAPACITY: cp_reg   = {33'd0, v[30:0]};
      REG_SOURCE_POWER:  pwr_reg  = {33'd0, v[30:0]};
      REG_FAR_TEMP:      amb_reg  = longint'(signed'(v));
      REG_MAX_TEMP:      tmax_reg = longint'(signed'(v));
      default: ;
    endcase
  endtask

  task automatic set_material(input logic [31:0] k, rho, cp, q, amb, tmax);
    write_reg(REG_CONDUCTIVITY, k);
    write_reg(REG_MASS_DENSITY, rho);
    write_reg(REG_HEAT_CAPACITY, cp);
    write_reg(REG_SOURCE_POWER, q);
    write_reg(REG_FAR_TEMP, amb);
    write_reg(REG_MAX_TEMP, tmax);
  endtask

  task automatic drain();
    wait (pending_pts.size() == 0 && !s_tvalid && heat_expected.size() == 0);
    repeat (LATENCY + 20) @(posedge clk);
  endtask

  task automatic random_run(input int count);
    for (int i = 0; i < count; i++) begin
      if (i % 100 == 0) burst_mode = ($urandom_range(0, 3) == 0);
      pending_pts.push_back(random_point());
    end
  endtask

  initial begin
    half_tab[0] = root64(64'd1 << 63);
    for (int i = 1; i < 16; i++) half_tab[i] = root64(half_tab[i-1] << 32);
    k_reg = 64'd65536; rho_reg = 64'd65536; cp_reg = 64'd65536; pwr_reg = 0;
    amb_reg = 0; tmax_reg = 64'sd2147483647;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // defaults: no power, so everything sits at ambient except zero radius
    random_run(60);
    drain();

    set_material(ONE, ONE, ONE, 1000 * ONE, 20 * ONE, 2000 * ONE);
    // zero radius
    pending_pts.push_back(mk(0, 0, 0, 0, 0, 0, 0, 0));
    pending_pts.push_back(mk(ONE, -ONE, 0, ONE, -ONE, 0, 0, ONE));
    // still source, pure radial falloff
    pending_pts.push_back(mk(ONE, 0, 0, 0, 0, 0, 0, 0));
    pending_pts.push_back(mk(0, 0, 5 * ONE, 0, 0, 0, 0, 7 * ONE));
    // ahead of and behind a moving source, both signs of velocity
    pending_pts.push_back(mk(2 * ONE, 0, ONE, ONE, 0, 0, 0, ONE / 2));
    pending_pts.push_back(mk(-2 * ONE, 0, ONE, ONE, 0, 0, 0, ONE / 2));
    pending_pts.push_back(mk(0, 2 * ONE, ONE, 0, -ONE, 0, 0, ONE));
    pending_pts.push_back(mk(0, -2 * ONE, ONE, -3 * ONE, 2 * ONE, ONE, 0, ONE));
    // straight behind a fast moving source: the exponent is zero
    pending_pts.push_back(mk(-100 * ONE, 0, 0, 100 * ONE, 0, 0, 0, 0));
    // offset overflow in both directions
    pending_pts.push_back(mk(32'sh7FFF_FFFF, 32'sh8000_0000, 0, 32'sh8000_0000,
                             32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF, 31'h7FFF_FFFF));
    pending_pts.push_back(mk(32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF,
                             32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh8000_0000, 31'h7FFF_FFFF));
    pending_pts.push_back(mk(-1, -1, -1, -1, -1, -1, -1, 31'h7FFF_FFFF));
    pending_pts.push_back(mk(1, 0, 0, 0, 0, 0, 0, 1));
    pending_pts.push_back(mk(0, 1, -1, 1, 1, -1, 0, 0));
    random_run(300);
    drain();

    // extremes: tiny conductivity and huge rho*cp, clamp at the top
    set_material(32'd1, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
                 32'h7FFF_FFFF);
    pending_pts.push_back(mk(ONE, 0, 0, 0, 0, 0, 0, 0));
    pending_pts.push_back(mk(ONE, 0, 0, 1, 0, 0, 0, 0));
    random_run(300);
    drain();

    // huge conductivity, clamp at the bottom
    set_material(32'h7FFF_FFFF, 32'd1, 32'd1, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000);
    random_run(300);
    drain();

    // mid-range materials, clamp sitting in the spread of results
    set_material(ONE / 4, 2 * ONE, 3 * ONE, 50 * ONE, 25 * ONE, 80 * ONE);
    random_run(300);
    drain();

    for (int ph = 0; ph < 3; ph++) begin
      set_material($urandom_range(1, 32'h7FFF_FFFF), $urandom_range(1, 8 * ONE),
                   $urandom_range(1, 8 * ONE), $urandom, $urandom, $urandom);
      random_run(260);
      drain();
    end

    if (errors == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

endmodule
